// ===== rtl/lrk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and microcode tables of the Lorenz RK4 integrator.
package lrk_pkg;

  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 24;
  localparam int HALF_BITS = WORD_BITS / 2;
  localparam int D6_BITS   = 16;
  localparam int STEP_BITS = 25;
  localparam int COUNT_BITS = 16;
  localparam int RHO_BITS  = 31;
  localparam int DIV_BITS  = STEP_BITS + D6_BITS + 1;
  localparam int RECIP_BITS = 26;
  localparam int RECIP_SHIFT = 28;
  localparam int DIV_PROD_BITS = STEP_BITS + RECIP_BITS;
  localparam int DEPTH     = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [RECIP_BITS-1:0] RECIP_SIX =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) / 64'd6) + 64'd1);

  localparam logic [WORD_BITS-1:0] SIGMA_VAL = WORD_BITS'(10) << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] BETA_VAL =
    WORD_BITS'(((64'd16 << FRAC_BITS) + 64'd3) / 64'd6);

  localparam logic [STEP_BITS-1:0]  TIME_STEP_RST  = STEP_BITS'(167772);
  localparam logic [COUNT_BITS-1:0] STEP_TOTAL_RST = COUNT_BITS'(1000);
  localparam logic [WORD_BITS-1:0]  START_RST      = WORD_BITS'(167772160);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_STEP  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_TOTAL = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_X    = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_Y    = 8'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_Z    = 8'd4;

  localparam logic [ADDR_BITS-1:0] A_POS   = 5'd0;
  localparam logic [ADDR_BITS-1:0] A_TRIAL = 5'd3;
  localparam logic [ADDR_BITS-1:0] A_SLOPE = 5'd6;
  localparam logic [ADDR_BITS-1:0] A_SUM   = 5'd9;
  localparam logic [ADDR_BITS-1:0] A_RHO   = 5'd12;
  localparam logic [ADDR_BITS-1:0] A_DT    = 5'd13;
  localparam logic [ADDR_BITS-1:0] A_D6    = 5'd14;
  localparam logic [ADDR_BITS-1:0] A_SIGMA = 5'd15;
  localparam logic [ADDR_BITS-1:0] A_BETA  = 5'd16;
  localparam logic [ADDR_BITS-1:0] A_ZERO  = 5'd17;
  localparam logic [ADDR_BITS-1:0] A_TMP1  = 5'd18;
  localparam logic [ADDR_BITS-1:0] A_TMP2  = 5'd19;

  localparam logic [3:0] LOAD_LAST  = 4'd9;
  localparam logic [3:0] LORENZ_LAST = 4'd8;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_code_t;
  typedef enum logic [1:0] {SH_FRAC, SH_HALF, SH_D6} shift_t;

  typedef struct packed {
    op_code_t             code;
    shift_t               sh;
    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] b;
    logic [ADDR_BITS-1:0] d;
  } op_t;

  typedef struct packed {
    logic     start;
    op_code_t code;
    shift_t   sh;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_LOAD, ST_RD, ST_EX, ST_WAIT, ST_FIN0, ST_FIN1, ST_FIN2, ST_OUT
  } state_t;

  // Fraction bits of dt/6 for a remainder r of dt/6: (r * 2^16 + 3) / 6.
  function automatic logic [D6_BITS-1:0] d6_frac(logic [2:0] r);
    logic [D6_BITS-1:0] f;
    case (r)
      3'd1:    f = D6_BITS'(10923);
      3'd2:    f = D6_BITS'(21845);
      3'd3:    f = D6_BITS'(32768);
      3'd4:    f = D6_BITS'(43691);
      3'd5:    f = D6_BITS'(54613);
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic op_t mk(op_code_t c, shift_t s, logic [ADDR_BITS-1:0] a,
                             logic [ADDR_BITS-1:0] b, logic [ADDR_BITS-1:0] d);
    op_t o;
    o.code = c;
    o.sh   = s;
    o.a    = a;
    o.b    = b;
    o.d    = d;
    return o;
  endfunction

  function automatic op_t lorenz_op(logic [3:0] idx, logic [ADDR_BITS-1:0] base);
    logic [ADDR_BITS-1:0] p0;
    logic [ADDR_BITS-1:0] p1;
    logic [ADDR_BITS-1:0] p2;
    op_t o;
    p0 = base;
    p1 = base + 5'd1;
    p2 = base + 5'd2;
    case (idx)
      4'd0: o = mk(OP_SUB, SH_FRAC, p1, p0, A_TMP1);
      4'd1: o = mk(OP_MUL, SH_FRAC, A_SIGMA, A_TMP1, A_SLOPE);
      4'd2: o = mk(OP_MUL, SH_FRAC, A_RHO, p0, A_TMP1);
      4'd3: o = mk(OP_SUB, SH_FRAC, A_TMP1, p1, A_TMP1);
      4'd4: o = mk(OP_MUL, SH_FRAC, p0, p2, A_TMP2);
      4'd5: o = mk(OP_SUB, SH_FRAC, A_TMP1, A_TMP2, A_SLOPE + 5'd1);
      4'd6: o = mk(OP_MUL, SH_FRAC, p0, p1, A_TMP1);
      4'd7: o = mk(OP_MUL, SH_FRAC, A_BETA, p2, A_TMP2);
      default: o = mk(OP_SUB, SH_FRAC, A_TMP1, A_TMP2, A_SLOPE + 5'd2);
    endcase
    return o;
  endfunction

  function automatic op_t update_op(logic [1:0] stage, logic [1:0] comp, logic [1:0] sub);
    logic [ADDR_BITS-1:0] k;
    logic [ADDR_BITS-1:0] p;
    logic [ADDR_BITS-1:0] t;
    logic [ADDR_BITS-1:0] s;
    shift_t hs;
    op_t o;
    k  = A_SLOPE + 5'(comp);
    p  = A_POS + 5'(comp);
    t  = A_TRIAL + 5'(comp);
    s  = A_SUM + 5'(comp);
    hs = (stage == 2'd1) ? SH_HALF : SH_FRAC;
    case (stage)
      2'd0: begin
        case (sub)
          2'd0:    o = mk(OP_ADD, SH_FRAC, k, A_ZERO, s);
          2'd1:    o = mk(OP_MUL, SH_HALF, k, A_DT, A_TMP1);
          default: o = mk(OP_ADD, SH_FRAC, p, A_TMP1, t);
        endcase
      end
      2'd3: begin
        case (sub)
          2'd0:    o = mk(OP_ADD, SH_FRAC, s, k, s);
          2'd1:    o = mk(OP_MUL, SH_D6, s, A_D6, A_TMP1);
          default: o = mk(OP_ADD, SH_FRAC, p, A_TMP1, p);
        endcase
      end
      default: begin
        case (sub)
          2'd0:    o = mk(OP_ADD, SH_FRAC, k, k, A_TMP1);
          2'd1:    o = mk(OP_ADD, SH_FRAC, s, A_TMP1, s);
          2'd2:    o = mk(OP_MUL, hs, k, A_DT, A_TMP1);
          default: o = mk(OP_ADD, SH_FRAC, p, A_TMP1, t);
        endcase
      end
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/lrk_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module lrk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/lrk_alu.sv =====
`timescale 1ns / 1ps
// Saturating add, subtract and rounding multiply on fixed-point words.
module lrk_alu (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lrk_pkg::alu_req_t                    req,
  input  logic [lrk_pkg::WORD_BITS-1:0]        a,
  input  logic [lrk_pkg::WORD_BITS-1:0]        b,
  output logic                                 done,
  output logic [lrk_pkg::WORD_BITS-1:0]        result,
  output logic                                 sat
);

  localparam int W = lrk_pkg::WORD_BITS;
  localparam int H = lrk_pkg::HALF_BITS;

  logic                   busy;
  lrk_pkg::op_code_t      code;
  lrk_pkg::shift_t        sh;
  logic [W-1:0]           opa;
  logic [W-1:0]           opb;
  logic [W-1:0]           ua;
  logic [W-1:0]           ub;
  logic                   neg;
  logic [2:0]             mcnt;
  logic [W-1:0]           pp;
  logic [1:0]             pp_pos;
  logic [2*W-1:0]         acc;

  logic [H-1:0]           a_half;
  logic [H-1:0]           b_half;
  logic [2*W-1:0]         pp_ext;
  logic [2*W-1:0]         rnd;
  logic [2*W-1:0]         q;
  logic [W:0]             sum;
  logic [W-1:0]           max_w;
  logic [W-1:0]           min_w;

  assign max_w = {1'b0, {(W-1){1'b1}}};
  assign min_w = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    a_half = mcnt[1] ? ua[W-1:H] : ua[H-1:0];
    b_half = mcnt[0] ? ub[W-1:H] : ub[H-1:0];
    case (pp_pos)
      2'd0:    pp_ext = {{W{1'b0}}, pp};
      2'd1:    pp_ext = {{W{1'b0}}, pp} << H;
      default: pp_ext = {{W{1'b0}}, pp} << (2 * H);
    endcase
    case (sh)
      lrk_pkg::SH_HALF: begin
        rnd = (2*W)'(1) << lrk_pkg::FRAC_BITS;
        q   = acc >> (lrk_pkg::FRAC_BITS + 1);
      end
      lrk_pkg::SH_D6: begin
        rnd = (2*W)'(1) << (lrk_pkg::FRAC_BITS + lrk_pkg::D6_BITS - 1);
        q   = acc >> (lrk_pkg::FRAC_BITS + lrk_pkg::D6_BITS);
      end
      default: begin
        rnd = (2*W)'(1) << (lrk_pkg::FRAC_BITS - 1);
        q   = acc >> lrk_pkg::FRAC_BITS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mcnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      mcnt <= '0;
    end else if (busy) begin
      mcnt <= mcnt + 3'd1;
      if (code != lrk_pkg::OP_MUL || mcnt == 3'd6) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      code <= req.code;
      sh   <= req.sh;
      opa  <= a;
      opb  <= b;
      ua   <= a[W-1] ? (~a + W'(1)) : a;
      ub   <= b[W-1] ? (~b + W'(1)) : b;
      neg  <= a[W-1] ^ b[W-1];
      acc  <= '0;
    end else if (busy) begin
      if (mcnt <= 3'd3) begin
        pp     <= W'(a_half) * W'(b_half);
        pp_pos <= {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
      end
      if (mcnt >= 3'd1 && mcnt <= 3'd4) begin
        acc <= acc + pp_ext;
      end else if (mcnt == 3'd5) begin
        acc <= acc + rnd;
      end
    end
  end

  always_comb begin
    sum = '0;
    result = '0;
    sat = 1'b0;
    case (code)
      lrk_pkg::OP_MUL: begin
        if (!neg) begin
          if (q > (2*W)'(max_w)) begin
            result = max_w;
            sat = 1'b1;
          end else begin
            result = q[W-1:0];
          end
        end else if (q > (2*W)'(min_w)) begin
          result = min_w;
          sat = 1'b1;
        end else begin
          result = ~q[W-1:0] + W'(1);
        end
      end
      default: begin
        if (code == lrk_pkg::OP_SUB) begin
          sum = {opa[W-1], opa} - {opb[W-1], opb};
        end else begin
          sum = {opa[W-1], opa} + {opb[W-1], opb};
        end
        if (sum[W] != sum[W-1]) begin
          result = sum[W] ? min_w : max_w;
          sat = 1'b1;
        end else begin
          result = sum[W-1:0];
        end
      end
    endcase
  end

  assign done = busy && (code != lrk_pkg::OP_MUL || mcnt == 3'd6);

endmodule

// ===== rtl/lorenz_rk4_integrator.sv =====
`timescale 1ns / 1ps
// Top level of the Lorenz RK4 integrator.
// Each accepted rho starts one problem from the configured start point and runs
// step_total RK4 steps; one result follows with the final point and a flag for
// any saturation. Problems run one at a time; a new rho is taken while the last
// result still waits. After a rho is accepted, dt/6 is formed by reciprocal
// multiplication, 10 load writes go into the state RAM, then each step runs 78
// micro-operations one after another through a single ALU (read, issue, write
// back; the multiply works on 24x24-bit partial products), the point is read
// out in ST_FIN0 to ST_FIN2 and the result is presented in ST_OUT. A result not
// yet taken stalls the following problem at its end.
module lorenz_rk4_integrator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [31:0]                            s_tdata,   // rho
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [143:0]                           m_tdata,   // final_x, final_y, final_z
  output logic [0:0]                             m_tuser,   // saturated
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lrk_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [lrk_pkg::WORD_BITS-1:0]          cfg_data
);

  localparam int W = lrk_pkg::WORD_BITS;
  localparam int AW = lrk_pkg::ADDR_BITS;

  lrk_pkg::state_t state, state_next;

  logic [lrk_pkg::STEP_BITS-1:0]  time_step;
  logic [lrk_pkg::COUNT_BITS-1:0] step_total;
  logic [W-1:0]                   start_x;
  logic [W-1:0]                   start_y;
  logic [W-1:0]                   start_z;

  logic [lrk_pkg::RHO_BITS-1:0]   rho;
  logic [lrk_pkg::DIV_PROD_BITS-1:0] div_prod;
  logic [lrk_pkg::STEP_BITS-1:0]  div_q;
  logic [2:0]                     div_left;
  logic [lrk_pkg::DIV_BITS-1:0]   d6;
  logic [3:0]                     load_cnt;
  logic [1:0]                     rk_stage;
  logic                           phase;
  logic [3:0]                     lidx;
  logic [1:0]                     comp;
  logic [1:0]                     sub;
  logic [lrk_pkg::COUNT_BITS-1:0] steps_done;
  logic                           sat_seen;
  logic [W-1:0]                   fx;
  logic [W-1:0]                   fy;

  logic [1:0]                     last_sub;
  logic                           last_op;
  lrk_pkg::op_t                   op;
  lrk_pkg::alu_req_t              alu_req;
  logic                           alu_done;
  logic [W-1:0]                   alu_result;
  logic                           alu_sat;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [W-1:0]                   ram_wdata;
  logic [AW-1:0]                  raddr_a;
  logic [AW-1:0]                  raddr_b;
  logic [W-1:0]                   rdata_a;
  logic [W-1:0]                   rdata_b;
  logic                           out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step  <= lrk_pkg::TIME_STEP_RST;
      step_total <= lrk_pkg::STEP_TOTAL_RST;
      start_x    <= lrk_pkg::START_RST;
      start_y    <= lrk_pkg::START_RST;
      start_z    <= lrk_pkg::START_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrk_pkg::CFG_TIME_STEP:  time_step  <= cfg_data[lrk_pkg::STEP_BITS-1:0];
        lrk_pkg::CFG_STEP_TOTAL: step_total <= cfg_data[lrk_pkg::COUNT_BITS-1:0];
        lrk_pkg::CFG_START_X:    start_x    <= cfg_data;
        lrk_pkg::CFG_START_Y:    start_y    <= cfg_data;
        lrk_pkg::CFG_START_Z:    start_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == lrk_pkg::ST_IDLE);

  always_comb begin
    last_sub = (rk_stage == 2'd0 || rk_stage == 2'd3) ? 2'd2 : 2'd3;
    last_op  = phase && sub == last_sub && comp == 2'd2 && rk_stage == 2'd3 &&
               steps_done == step_total - 16'd1;
    if (!phase) begin
      op = lrk_pkg::lorenz_op(lidx, (rk_stage == 2'd0) ? lrk_pkg::A_POS : lrk_pkg::A_TRIAL);
    end else begin
      op = lrk_pkg::update_op(rk_stage, comp, sub);
    end
    div_q    = lrk_pkg::STEP_BITS'(
                 div_prod[lrk_pkg::DIV_PROD_BITS-1:lrk_pkg::RECIP_SHIFT]);
    div_left = 3'(time_step - (div_q << 2) - (div_q << 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load = 1'b0;
    case (state)
      lrk_pkg::ST_IDLE: if (s_tvalid) state_next = lrk_pkg::ST_DIV;
      lrk_pkg::ST_DIV: state_next = lrk_pkg::ST_LOAD;
      lrk_pkg::ST_LOAD: begin
        if (load_cnt == lrk_pkg::LOAD_LAST) begin
          state_next = (step_total == '0) ? lrk_pkg::ST_FIN0 : lrk_pkg::ST_RD;
        end
      end
      lrk_pkg::ST_RD: state_next = lrk_pkg::ST_EX;
      lrk_pkg::ST_EX: state_next = lrk_pkg::ST_WAIT;
      lrk_pkg::ST_WAIT: begin
        if (alu_done) state_next = last_op ? lrk_pkg::ST_FIN0 : lrk_pkg::ST_RD;
      end
      lrk_pkg::ST_FIN0: state_next = lrk_pkg::ST_FIN1;
      lrk_pkg::ST_FIN1: state_next = lrk_pkg::ST_FIN2;
      lrk_pkg::ST_FIN2: state_next = lrk_pkg::ST_OUT;
      lrk_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = lrk_pkg::ST_IDLE;
        end
      end
      default: state_next = lrk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt   <= '0;
      rk_stage   <= '0;
      phase      <= 1'b0;
      lidx       <= '0;
      comp       <= '0;
      sub        <= '0;
      steps_done <= '0;
      sat_seen   <= 1'b0;
    end else begin
      case (state)
        lrk_pkg::ST_IDLE: begin
          load_cnt   <= '0;
          rk_stage   <= '0;
          phase      <= 1'b0;
          lidx       <= '0;
          comp       <= '0;
          sub        <= '0;
          steps_done <= '0;
          sat_seen   <= 1'b0;
        end
        lrk_pkg::ST_LOAD: load_cnt <= load_cnt + 4'd1;
        lrk_pkg::ST_WAIT: begin
          if (alu_done) begin
            sat_seen <= sat_seen | alu_sat;
            if (!phase) begin
              if (lidx == lrk_pkg::LORENZ_LAST) begin
                phase <= 1'b1;
                comp  <= '0;
                sub   <= '0;
              end else begin
                lidx <= lidx + 4'd1;
              end
            end else if (sub == last_sub) begin
              sub <= '0;
              if (comp == 2'd2) begin
                comp  <= '0;
                phase <= 1'b0;
                lidx  <= '0;
                rk_stage <= rk_stage + 2'd1;
                if (rk_stage == 2'd3) begin
                  steps_done <= steps_done + 16'd1;
                end
              end else begin
                comp <= comp + 2'd1;
              end
            end else begin
              sub <= sub + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == lrk_pkg::ST_IDLE) begin
      rho      <= s_tdata[lrk_pkg::RHO_BITS-1:0];
      div_prod <= lrk_pkg::DIV_PROD_BITS'(time_step) *
                  lrk_pkg::DIV_PROD_BITS'(lrk_pkg::RECIP_SIX);
    end else if (state == lrk_pkg::ST_DIV) begin
      d6 <= lrk_pkg::DIV_BITS'({div_q, lrk_pkg::d6_frac(div_left)});
    end
    if (state == lrk_pkg::ST_FIN1) begin
      fx <= rdata_a;
      fy <= rdata_b;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op.d;
    ram_wdata = alu_result;
    if (state == lrk_pkg::ST_LOAD) begin
      ram_we = 1'b1;
      case (load_cnt)
        4'd0: begin ram_waddr = lrk_pkg::A_POS;          ram_wdata = start_x; end
        4'd1: begin ram_waddr = lrk_pkg::A_POS + 5'd1;   ram_wdata = start_y; end
        4'd2: begin ram_waddr = lrk_pkg::A_POS + 5'd2;   ram_wdata = start_z; end
        4'd3: begin ram_waddr = lrk_pkg::A_RHO;          ram_wdata = W'(rho); end
        4'd4: begin ram_waddr = lrk_pkg::A_DT;           ram_wdata = W'(time_step); end
        4'd5: begin ram_waddr = lrk_pkg::A_D6;           ram_wdata = W'(d6); end
        4'd6: begin ram_waddr = lrk_pkg::A_SIGMA;        ram_wdata = lrk_pkg::SIGMA_VAL; end
        4'd7: begin ram_waddr = lrk_pkg::A_BETA;         ram_wdata = lrk_pkg::BETA_VAL; end
        4'd8: begin ram_waddr = lrk_pkg::A_ZERO;         ram_wdata = '0; end
        default: begin ram_waddr = lrk_pkg::A_TMP2;      ram_wdata = '0; end
      endcase
    end else if (state == lrk_pkg::ST_WAIT && alu_done) begin
      ram_we = 1'b1;
    end
    case (state)
      lrk_pkg::ST_FIN0: begin
        raddr_a = lrk_pkg::A_POS;
        raddr_b = lrk_pkg::A_POS + 5'd1;
      end
      lrk_pkg::ST_FIN1: begin
        raddr_a = lrk_pkg::A_POS + 5'd2;
        raddr_b = op.b;
      end
      default: begin
        raddr_a = op.a;
        raddr_b = op.b;
      end
    endcase
    alu_req.start = (state == lrk_pkg::ST_EX);
    alu_req.code  = op.code;
    alu_req.sh    = op.sh;
  end

  lrk_ram #(
    .WIDTH(W),
    .DEPTH(lrk_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  lrk_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rdata_a),
    .b      (rdata_b),
    .done   (alu_done),
    .result (alu_result),
    .sat    (alu_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  logic [W-1:0] fz;

  always_ff @(posedge clk) begin
    if (state == lrk_pkg::ST_FIN2) begin
      fz <= rdata_a;
    end
    if (out_load) begin
      m_tdata <= {fz, fy, fx};
      m_tuser <= sat_seen;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == lrk_pkg::ST_WAIT)
    else $error("ALU completion outside write-back");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == lrk_pkg::ST_DIV)
    else $error("accepted transaction did not start a problem");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result not presented");
`endif

endmodule
